>>> rtl/assert_macros.svh
// Assertion macros included by the sorted key table module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, switched off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, payload structs, status codes and controller states shared by the
// sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Table capacity and the widths that follow from it.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths of the input and result items.
    localparam int KEY_W = 16;
    localparam int POS_W = 9;

    // Item mode codes.
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Input item.
    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } t_in;

    // Result item.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        t_status          status;
        logic [POS_W-1:0] entries;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_HIT_CHECK,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESULT
    } t_state;

endpackage

>>> rtl/sorted_key_table_insert_lookup.sv
// ----------------------------------------------------------------------------
// Sorted key table with lookup and ordered insert
// Holds an ascending table of unique keys in a synchronous RAM. Each item is
// binary-searched; a new key on insert shifts the upper entries up one place.
//
//   Channel   Signals                               Direction
//   in        i_in_valid, o_in_ready, i_in_data     item into the block
//   out       o_out_valid, i_out_ready, o_out_data  result out of the block
//
// One item is worked at a time. Each halving step of the search is a RAM
// read, then a compare, with at most ceil(log2(N+1)) steps for N stored keys,
// then a closing read and the hit check. An insert of a new key then shifts
// the entries from the last down to its position one place up through the
// single RAM read and write ports and places the key; a key that goes at the
// end is placed without a shift. The worst case is an insert at position 0
// into 255 keys. Reset is synchronous and active low; it empties the table
// at once, no clearing pass. A held result stalls only the final step of the
// next item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_table_insert_lookup
    import skt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Key storage, one read and one write port, registered read data.
    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;

    // Control and working registers.
    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic              r_found, n_found;
    t_status           r_status, n_status;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // Shared combinational terms.
    logic [CNT_W-1:0] mid;
    logic             hit;
    logic             full;
    logic             out_free;
    logic             do_insert;

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign hit       = (r_lo < r_count) && (r_rd_data == r_key);
    assign full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign out_free  = !r_out_valid || i_out_ready;
    assign do_insert = (r_mode == MODE_INSERT) && !hit && !full;

    // RAM ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_state = (r_lo < r_hi) ? S_COMPARE : S_HIT_CHECK;
            end
            S_COMPARE: begin
                n_state = S_SEARCH;
            end
            S_HIT_CHECK: begin
                if (!do_insert) begin
                    n_state = S_RESULT;
                end else if (r_lo == r_count) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_idx == r_lo[ADDR_W-1:0]) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath registers and RAM control.
    always_comb begin
        n_mode      = r_mode;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        rd_addr     = r_lo[ADDR_W-1:0];
        mem_we      = 1'b0;
        wr_addr     = ADDR_W'(r_pend_addr + ADDR_W'(1));
        wr_data     = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode = i_in_data.mode;
                    n_key  = i_in_data.key;
                    n_lo   = '0;
                    n_hi   = r_count;
                end
            end
            S_SEARCH: begin
                // Read the midpoint while the range is open, else the bound.
                if (r_lo < r_hi) begin
                    rd_addr = mid[ADDR_W-1:0];
                end
            end
            S_COMPARE: begin
                if (r_rd_data < r_key) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                end
            end
            S_HIT_CHECK: begin
                n_found  = hit;
                n_pend   = 1'b0;
                n_idx    = ADDR_W'(r_count - CNT_W'(1));
                n_status = ST_DONE;
                if (r_mode == MODE_INSERT) begin
                    if (hit) begin
                        n_status = ST_DUP;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_SHIFT: begin
                // Read one entry per cycle, write the previous one a place up.
                rd_addr     = r_idx;
                mem_we      = r_pend;
                n_pend      = 1'b1;
                n_pend_addr = r_idx;
                n_idx       = r_idx - ADDR_W'(1);
            end
            S_DRAIN: begin
                mem_we = 1'b1;
            end
            S_PUT: begin
                mem_we  = 1'b1;
                wr_addr = r_lo[ADDR_W-1:0];
                wr_data = r_key;
                n_count = r_count + CNT_W'(1);
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.found    = r_found;
                    n_out.position = POS_W'(r_lo);
                    n_out.status   = r_status;
                    n_out.entries  = POS_W'(r_count);
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_found     <= n_found;
        r_status    <= n_status;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The entry count never passes the capacity.
    `ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH), "count over capacity")

    // The RAM is written only while an insert shifts or places its key.
    `ASSERT_RST(a_write_phase, i_clk, i_rst_n, mem_we |-> (r_state == S_SHIFT || r_state == S_DRAIN || r_state == S_PUT), "RAM write outside insert")

    // Placing a key grows the table by exactly one.
    `ASSERT_RST(a_count_step, i_clk, i_rst_n, (r_state == S_PUT) |=> (r_count == $past(r_count) + CNT_W'(1)), "count did not step")

    // The search range stays ordered.
    `ASSERT_RST(a_range_order, i_clk, i_rst_n, (r_state == S_SEARCH || r_state == S_COMPARE) |-> (r_lo <= r_hi), "search range inverted")

endmodule
